// ===== sv/alss_pkg.sv =====
// ----------------------------------------------------------------------------
// List engine package
// Shared operation codes, status codes, micro-operation codes and the
// command and status bundles passed between the controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package alss_pkg;

    localparam int DEF_CAPACITY = 64;

    localparam int MODE_W  = 4;
    localparam int VALUE_W = 32;
    localparam int POS_W   = 7;
    localparam int STAT_W  = 2;
    localparam int FIDX_W  = 6;
    localparam int CNT_W   = 7;

    localparam logic [MODE_W-1:0] MODE_CLEAR   = 4'd0;
    localparam logic [MODE_W-1:0] MODE_APPEND  = 4'd1;
    localparam logic [MODE_W-1:0] MODE_INSERT  = 4'd2;
    localparam logic [MODE_W-1:0] MODE_UPDATE  = 4'd3;
    localparam logic [MODE_W-1:0] MODE_DELETE  = 4'd4;
    localparam logic [MODE_W-1:0] MODE_SORTDSC = 4'd5;
    localparam logic [MODE_W-1:0] MODE_SORTASC = 4'd6;
    localparam logic [MODE_W-1:0] MODE_LSEARCH = 4'd7;
    localparam logic [MODE_W-1:0] MODE_BSEARCH = 4'd8;
    localparam logic [MODE_W-1:0] MODE_READ    = 4'd9;

    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STAT_W-1:0] ST_BADPOS   = 2'd2;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd3;

    localparam int UOP_W = 5;
    localparam logic [UOP_W-1:0] UOP_NONE      = 5'd0;
    localparam logic [UOP_W-1:0] UOP_LOAD      = 5'd1;
    localparam logic [UOP_W-1:0] UOP_CLEAR     = 5'd2;
    localparam logic [UOP_W-1:0] UOP_ERR_FULL  = 5'd3;
    localparam logic [UOP_W-1:0] UOP_ERR_POS   = 5'd4;
    localparam logic [UOP_W-1:0] UOP_APPEND    = 5'd5;
    localparam logic [UOP_W-1:0] UOP_UPDATE    = 5'd6;
    localparam logic [UOP_W-1:0] UOP_INS_INIT  = 5'd7;
    localparam logic [UOP_W-1:0] UOP_INS_RD    = 5'd8;
    localparam logic [UOP_W-1:0] UOP_INS_WR    = 5'd9;
    localparam logic [UOP_W-1:0] UOP_INS_PUT   = 5'd10;
    localparam logic [UOP_W-1:0] UOP_DEL_INIT  = 5'd11;
    localparam logic [UOP_W-1:0] UOP_DEL_RD    = 5'd12;
    localparam logic [UOP_W-1:0] UOP_DEL_WR    = 5'd13;
    localparam logic [UOP_W-1:0] UOP_DEL_FIN   = 5'd14;
    localparam logic [UOP_W-1:0] UOP_SORT_INIT = 5'd15;
    localparam logic [UOP_W-1:0] UOP_SORT_RDI  = 5'd16;
    localparam logic [UOP_W-1:0] UOP_SORT_LDA  = 5'd17;
    localparam logic [UOP_W-1:0] UOP_SORT_CMP  = 5'd18;
    localparam logic [UOP_W-1:0] UOP_SORT_WB   = 5'd19;
    localparam logic [UOP_W-1:0] UOP_LIN_INIT  = 5'd20;
    localparam logic [UOP_W-1:0] UOP_LIN_RD    = 5'd21;
    localparam logic [UOP_W-1:0] UOP_LIN_CMP   = 5'd22;
    localparam logic [UOP_W-1:0] UOP_BIN_INIT  = 5'd23;
    localparam logic [UOP_W-1:0] UOP_BIN_RD    = 5'd24;
    localparam logic [UOP_W-1:0] UOP_BIN_CMP   = 5'd25;
    localparam logic [UOP_W-1:0] UOP_RD_ISSUE  = 5'd26;
    localparam logic [UOP_W-1:0] UOP_RD_TAKE   = 5'd27;
    localparam logic [UOP_W-1:0] UOP_EMIT      = 5'd28;

    typedef struct packed {
        logic [UOP_W-1:0] uop;
    } t_cmd;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              full;
        logic              pos_bad;
        logic              ins_bad;
        logic              ins_more;
        logic              del_more;
        logic              sort_more;
        logic              j_more;
        logic              lin_more;
        logic              bin_more;
        logic              eq;
    } t_stat;

endpackage

`default_nettype wire

// ===== sv/alss_dp.sv =====
// ----------------------------------------------------------------------------
// List engine datapath
// Element memory, element count, loop indices and result registers, driven
// one micro-operation per cycle by the controller.
// ----------------------------------------------------------------------------
`default_nettype none

module alss_dp
    import alss_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire t_cmd                      i_cmd,
    output t_stat                          o_stat,
    input  wire logic [MODE_W-1:0]         i_mode,
    input  wire logic signed [VALUE_W-1:0] i_value,
    input  wire logic [POS_W-1:0]          i_position,
    output logic [STAT_W-1:0]              o_status,
    output logic [FIDX_W-1:0]              o_found_index,
    output logic signed [VALUE_W-1:0]      o_read_value,
    output logic [CNT_W-1:0]               o_count
);

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > POS_W) ? CW : POS_W;

    logic signed [VALUE_W-1:0] r_mem [CAPACITY];
    logic signed [VALUE_W-1:0] r_rdata;

    logic [MODE_W-1:0]         r_mode;
    logic signed [VALUE_W-1:0] r_val;
    logic [POS_W-1:0]          r_pos;
    logic [CW-1:0]             r_cnt;
    logic [CW-1:0]             r_i;
    logic [CW-1:0]             r_j;
    logic signed [VALUE_W-1:0] r_a;
    logic signed [CW:0]        r_lo;
    logic signed [CW:0]        r_hi;
    logic [STAT_W-1:0]         r_st;
    logic [FIDX_W-1:0]         r_fd;
    logic signed [VALUE_W-1:0] r_rv;

    logic                      we;
    logic [IW-1:0]             waddr;
    logic signed [VALUE_W-1:0] wdata;
    logic [IW-1:0]             raddr;

    logic [XW-1:0]             pos_x;
    logic [XW-1:0]             cnt_x;
    logic [CW+1:0]             mid_sum;
    logic [CW-1:0]             mid;
    logic                      swap;

    assign pos_x   = XW'(r_pos);
    assign cnt_x   = XW'(r_cnt);
    assign mid_sum = (CW+2)'(r_lo) + (CW+2)'(r_hi);
    assign mid     = mid_sum[CW:1];
    assign swap    = (r_mode == MODE_SORTASC) ? (r_a > r_rdata) : (r_a < r_rdata);

    always_comb begin
        o_stat.mode      = r_mode;
        o_stat.full      = (r_cnt >= CW'(CAPACITY));
        o_stat.pos_bad   = (pos_x >= cnt_x);
        o_stat.ins_bad   = (pos_x > cnt_x);
        o_stat.ins_more  = (XW'(r_i) > pos_x);
        o_stat.del_more  = ((CW+1)'(r_i) + 1'b1 < (CW+1)'(r_cnt));
        o_stat.sort_more = ((CW+1)'(r_i) + 1'b1 < (CW+1)'(r_cnt));
        o_stat.j_more    = ((CW+1)'(r_j) + 1'b1 < (CW+1)'(r_cnt));
        o_stat.lin_more  = (r_i < r_cnt);
        o_stat.bin_more  = (r_lo <= r_hi);
        o_stat.eq        = (r_rdata == r_val);
    end

    always_comb begin
        we    = 1'b0;
        waddr = r_i[IW-1:0];
        wdata = r_rdata;
        raddr = r_i[IW-1:0];
        case (i_cmd.uop)
            UOP_APPEND: begin
                we    = 1'b1;
                waddr = r_cnt[IW-1:0];
                wdata = r_val;
            end
            UOP_UPDATE, UOP_INS_PUT: begin
                we    = 1'b1;
                waddr = pos_x[IW-1:0];
                wdata = r_val;
            end
            UOP_INS_RD:  raddr = IW'(r_i - 1'b1);
            UOP_INS_WR:  we = 1'b1;
            UOP_DEL_RD:  raddr = IW'(r_i + 1'b1);
            UOP_DEL_WR:  we = 1'b1;
            UOP_SORT_LDA: raddr = r_j[IW-1:0];
            UOP_SORT_CMP: begin
                we    = swap;
                waddr = r_j[IW-1:0];
                wdata = r_a;
                raddr = IW'(r_j + 1'b1);
            end
            UOP_SORT_WB: begin
                we    = 1'b1;
                wdata = r_a;
            end
            UOP_BIN_RD:   raddr = mid[IW-1:0];
            UOP_RD_ISSUE: raddr = pos_x[IW-1:0];
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        r_rdata <= r_mem[raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            case (i_cmd.uop)
                UOP_CLEAR:              r_cnt <= '0;
                UOP_APPEND, UOP_INS_PUT: r_cnt <= r_cnt + 1'b1;
                UOP_DEL_FIN:            r_cnt <= r_cnt - 1'b1;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.uop)
            UOP_LOAD: begin
                r_mode <= i_mode;
                r_val  <= i_value;
                r_pos  <= i_position;
                r_st   <= ST_OK;
                r_fd   <= '0;
                r_rv   <= '0;
            end
            UOP_ERR_FULL:  r_st <= ST_FULL;
            UOP_ERR_POS:   r_st <= ST_BADPOS;
            UOP_INS_INIT:  r_i <= r_cnt;
            UOP_INS_WR:    r_i <= r_i - 1'b1;
            UOP_DEL_INIT:  r_i <= CW'(pos_x);
            UOP_DEL_WR:    r_i <= r_i + 1'b1;
            UOP_SORT_INIT: r_i <= '0;
            UOP_SORT_RDI:  r_j <= r_i + 1'b1;
            UOP_SORT_LDA:  r_a <= r_rdata;
            UOP_SORT_CMP: begin
                if (swap) begin
                    r_a <= r_rdata;
                end
                r_j <= r_j + 1'b1;
            end
            UOP_SORT_WB:   r_i <= r_i + 1'b1;
            UOP_LIN_INIT: begin
                r_i  <= '0;
                r_st <= ST_NOTFOUND;
            end
            UOP_LIN_CMP: begin
                if (r_rdata == r_val) begin
                    r_st <= ST_OK;
                    r_fd <= FIDX_W'(r_i);
                end else begin
                    r_i <= r_i + 1'b1;
                end
            end
            UOP_BIN_INIT: begin
                r_lo <= '0;
                r_hi <= $signed({1'b0, r_cnt} - (CW+1)'(1));
                r_st <= ST_NOTFOUND;
            end
            UOP_BIN_RD:    r_i <= mid;
            UOP_BIN_CMP: begin
                if (r_rdata == r_val) begin
                    r_st <= ST_OK;
                    r_fd <= FIDX_W'(r_i);
                end else if (r_rdata < r_val) begin
                    r_lo <= $signed({1'b0, r_i} + (CW+1)'(1));
                end else begin
                    r_hi <= $signed({1'b0, r_i} - (CW+1)'(1));
                end
            end
            UOP_RD_TAKE:   r_rv <= r_rdata;
            UOP_EMIT: begin
                o_status      <= r_st;
                o_found_index <= r_fd;
                o_read_value  <= r_rv;
                o_count       <= CNT_W'(r_cnt);
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/alss_ctrl.sv =====
// ----------------------------------------------------------------------------
// List engine controller
// Sequences each operation as a run of datapath micro-operations and owns
// the handshakes on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module alss_ctrl
    import alss_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_in_valid,
    output logic       o_in_stall,
    output logic       o_out_valid,
    input  wire logic  i_out_stall,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_DISP    = 4'd1;
    localparam logic [3:0] S_INS_RD  = 4'd2;
    localparam logic [3:0] S_INS_WR  = 4'd3;
    localparam logic [3:0] S_DEL_RD  = 4'd4;
    localparam logic [3:0] S_DEL_WR  = 4'd5;
    localparam logic [3:0] S_SORT_I  = 4'd6;
    localparam logic [3:0] S_SORT_A  = 4'd7;
    localparam logic [3:0] S_SORT_J  = 4'd8;
    localparam logic [3:0] S_SORT_WB = 4'd9;
    localparam logic [3:0] S_LIN_RD  = 4'd10;
    localparam logic [3:0] S_LIN_CMP = 4'd11;
    localparam logic [3:0] S_BIN_RD  = 4'd12;
    localparam logic [3:0] S_BIN_CMP = 4'd13;
    localparam logic [3:0] S_RD_WAIT = 4'd14;
    localparam logic [3:0] S_RESP    = 4'd15;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       r_ovalid;
    logic       n_ovalid;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ovalid;

    always_comb begin
        n_state   = r_state;
        n_ovalid  = r_ovalid && i_out_stall;
        o_cmd.uop = UOP_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.uop = UOP_LOAD;
                    n_state   = S_DISP;
                end
            end
            S_DISP: begin
                n_state = S_RESP;
                case (i_stat.mode)
                    MODE_CLEAR:  o_cmd.uop = UOP_CLEAR;
                    MODE_APPEND: o_cmd.uop = i_stat.full ? UOP_ERR_FULL : UOP_APPEND;
                    MODE_INSERT: begin
                        if (i_stat.full) begin
                            o_cmd.uop = UOP_ERR_FULL;
                        end else if (i_stat.ins_bad) begin
                            o_cmd.uop = UOP_ERR_POS;
                        end else begin
                            o_cmd.uop = UOP_INS_INIT;
                            n_state   = S_INS_RD;
                        end
                    end
                    MODE_UPDATE: o_cmd.uop = i_stat.pos_bad ? UOP_ERR_POS : UOP_UPDATE;
                    MODE_DELETE: begin
                        if (i_stat.pos_bad) begin
                            o_cmd.uop = UOP_ERR_POS;
                        end else begin
                            o_cmd.uop = UOP_DEL_INIT;
                            n_state   = S_DEL_RD;
                        end
                    end
                    MODE_SORTDSC, MODE_SORTASC: begin
                        o_cmd.uop = UOP_SORT_INIT;
                        n_state   = S_SORT_I;
                    end
                    MODE_LSEARCH: begin
                        o_cmd.uop = UOP_LIN_INIT;
                        n_state   = S_LIN_RD;
                    end
                    MODE_BSEARCH: begin
                        o_cmd.uop = UOP_BIN_INIT;
                        n_state   = S_BIN_RD;
                    end
                    MODE_READ: begin
                        if (i_stat.pos_bad) begin
                            o_cmd.uop = UOP_ERR_POS;
                        end else begin
                            o_cmd.uop = UOP_RD_ISSUE;
                            n_state   = S_RD_WAIT;
                        end
                    end
                    default: o_cmd.uop = UOP_NONE;
                endcase
            end
            S_INS_RD: begin
                if (i_stat.ins_more) begin
                    o_cmd.uop = UOP_INS_RD;
                    n_state   = S_INS_WR;
                end else begin
                    o_cmd.uop = UOP_INS_PUT;
                    n_state   = S_RESP;
                end
            end
            S_INS_WR: begin
                o_cmd.uop = UOP_INS_WR;
                n_state   = S_INS_RD;
            end
            S_DEL_RD: begin
                if (i_stat.del_more) begin
                    o_cmd.uop = UOP_DEL_RD;
                    n_state   = S_DEL_WR;
                end else begin
                    o_cmd.uop = UOP_DEL_FIN;
                    n_state   = S_RESP;
                end
            end
            S_DEL_WR: begin
                o_cmd.uop = UOP_DEL_WR;
                n_state   = S_DEL_RD;
            end
            S_SORT_I: begin
                if (i_stat.sort_more) begin
                    o_cmd.uop = UOP_SORT_RDI;
                    n_state   = S_SORT_A;
                end else begin
                    n_state = S_RESP;
                end
            end
            S_SORT_A: begin
                o_cmd.uop = UOP_SORT_LDA;
                n_state   = S_SORT_J;
            end
            S_SORT_J: begin
                o_cmd.uop = UOP_SORT_CMP;
                if (!i_stat.j_more) begin
                    n_state = S_SORT_WB;
                end
            end
            S_SORT_WB: begin
                o_cmd.uop = UOP_SORT_WB;
                n_state   = S_SORT_I;
            end
            S_LIN_RD: begin
                if (i_stat.lin_more) begin
                    o_cmd.uop = UOP_LIN_RD;
                    n_state   = S_LIN_CMP;
                end else begin
                    n_state = S_RESP;
                end
            end
            S_LIN_CMP: begin
                o_cmd.uop = UOP_LIN_CMP;
                n_state   = i_stat.eq ? S_RESP : S_LIN_RD;
            end
            S_BIN_RD: begin
                if (i_stat.bin_more) begin
                    o_cmd.uop = UOP_BIN_RD;
                    n_state   = S_BIN_CMP;
                end else begin
                    n_state = S_RESP;
                end
            end
            S_BIN_CMP: begin
                o_cmd.uop = UOP_BIN_CMP;
                n_state   = i_stat.eq ? S_RESP : S_BIN_RD;
            end
            S_RD_WAIT: begin
                o_cmd.uop = UOP_RD_TAKE;
                n_state   = S_RESP;
            end
            S_RESP: begin
                if (!r_ovalid || !i_out_stall) begin
                    o_cmd.uop = UOP_EMIT;
                    n_ovalid  = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

endmodule

`default_nettype wire

// ===== sv/array_list_sort_search_engine.sv =====
// ----------------------------------------------------------------------------
// Bounded list engine with exchange sort and searches
// Keeps up to CAPACITY signed 32-bit values and answers one result item for
// every operation item: clear, append, insert, update, delete, sort, search, read.
// ----------------------------------------------------------------------------
// Usage: the input channel takes an item (mode, value, position) when
// i_in_valid is high and o_in_stall is low. The block works on one item at a
// time; o_in_stall is high from acceptance until the result has been placed
// in the output register. Each item yields exactly one result item, offered
// with o_out_valid and taken at an edge where i_out_stall is low.
// Sorting makes one comparison per cycle, set by the single memory read
// port. The next item is accepted while the previous result still waits
// in the output register.
// If the receiver stalls, the result holds and one further item may be
// processed; its result then waits until the output register frees up.
// Reset clears the element count and the control state; memory contents are
// left as they are and are never observed beyond the count.
// ----------------------------------------------------------------------------
`default_nettype none

module array_list_sort_search_engine
    import alss_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    output logic                           o_in_stall,
    input  wire logic [MODE_W-1:0]         i_mode,
    input  wire logic signed [VALUE_W-1:0] i_value,
    input  wire logic [POS_W-1:0]          i_position,
    output logic                           o_out_valid,
    input  wire logic                      i_out_stall,
    output logic [STAT_W-1:0]              o_status,
    output logic [FIDX_W-1:0]              o_found_index,
    output logic signed [VALUE_W-1:0]      o_read_value,
    output logic [CNT_W-1:0]               o_count
);

    // Controller to datapath commands and the status flags coming back.
    t_cmd  cmd;
    t_stat stat;

    alss_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    alss_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_mode        (i_mode),
        .i_value       (i_value),
        .i_position    (i_position),
        .o_status      (o_status),
        .o_found_index (o_found_index),
        .o_read_value  (o_read_value),
        .o_count       (o_count)
    );

endmodule

`default_nettype wire

// ===== bench/array_list_sort_search_engine_test.sv =====
// ----------------------------------------------------------------------------
// List engine testbench
// Drives random and directed operation items into the list engine, predicts
// every result with a behavioural copy of the list and checks each result item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module array_list_sort_search_engine_test
    import alss_pkg::*;
();

    localparam int CAP = DEF_CAPACITY;
    localparam int WATCHDOG_LIMIT = 40000;

    typedef struct packed {
        logic [STAT_W-1:0]        status;
        logic [FIDX_W-1:0]        found_index;
        logic signed [VALUE_W-1:0] read_value;
        logic [CNT_W-1:0]         count;
    } t_answer;

    // The scoreboard keeps its own copy of the list and the queue of answers
    // that are still owed by the block.
    class list_scoreboard;
        logic signed [VALUE_W-1:0] shadow [CAP];
        int unsigned               used;
        t_answer                   owed [$];
        int unsigned               mismatches;

        function new();
            used = 0;
            mismatches = 0;
            foreach (shadow[k]) shadow[k] = '0;
        endfunction

        function void sort_shadow(bit ascending);
            logic signed [VALUE_W-1:0] t;
            for (int a = 0; a + 1 < used; a++)
                for (int b = a + 1; b < used; b++)
                    if (ascending ? (shadow[a] > shadow[b]) : (shadow[a] < shadow[b])) begin
                        t = shadow[a];
                        shadow[a] = shadow[b];
                        shadow[b] = t;
                    end
        endfunction

        // Applies one accepted item to the shadow list and queues its answer.
        function void note_item(logic [MODE_W-1:0] mode, logic signed [VALUE_W-1:0] val,
                                logic [POS_W-1:0] pos);
            t_answer ans;
            int lo, hi, mid;
            ans = '0;
            case (mode)
                MODE_CLEAR: used = 0;
                MODE_APPEND: begin
                    if (used >= CAP) ans.status = ST_FULL;
                    else begin
                        shadow[used] = val;
                        used++;
                    end
                end
                MODE_INSERT: begin
                    if (used >= CAP) ans.status = ST_FULL;
                    else if (pos > used) ans.status = ST_BADPOS;
                    else begin
                        for (int k = used; k > pos; k--) shadow[k] = shadow[k-1];
                        shadow[pos] = val;
                        used++;
                    end
                end
                MODE_UPDATE: begin
                    if (pos >= used) ans.status = ST_BADPOS;
                    else shadow[pos] = val;
                end
                MODE_DELETE: begin
                    if (pos >= used) ans.status = ST_BADPOS;
                    else begin
                        for (int k = pos; k + 1 < used; k++) shadow[k] = shadow[k+1];
                        used--;
                    end
                end
                MODE_SORTDSC: sort_shadow(1'b0);
                MODE_SORTASC: sort_shadow(1'b1);
                MODE_LSEARCH: begin
                    ans.status = ST_NOTFOUND;
                    for (int k = 0; k < used; k++)
                        if (shadow[k] == val) begin
                            ans.status = ST_OK;
                            ans.found_index = FIDX_W'(k);
                            break;
                        end
                end
                MODE_BSEARCH: begin
                    lo = 0;
                    hi = int'(used) - 1;
                    ans.status = ST_NOTFOUND;
                    while (lo <= hi) begin
                        mid = (lo + hi) / 2;
                        if (shadow[mid] == val) begin
                            ans.status = ST_OK;
                            ans.found_index = FIDX_W'(mid);
                            break;
                        end else if (shadow[mid] < val) lo = mid + 1;
                        else hi = mid - 1;
                    end
                end
                MODE_READ: begin
                    if (pos >= used) ans.status = ST_BADPOS;
                    else ans.read_value = shadow[pos];
                end
                default: ;
            endcase
            ans.count = CNT_W'(used);
            owed.push_back(ans);
        endfunction

        function void check_answer(t_answer got);
            t_answer want;
            if (owed.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: result item with none expected: %p", got);
                return;
            end
            want = owed.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"ERROR: status %0d/%0d index %0d/%0d value %0d/%0d ",
                              "count %0d/%0d (exp/act)"},
                             want.status, got.status, want.found_index, got.found_index,
                             want.read_value, got.read_value, want.count, got.count);
            end
        endfunction
    endclass

    logic                       clk;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_stall;
    logic [MODE_W-1:0]          mode;
    logic signed [VALUE_W-1:0]  value;
    logic [POS_W-1:0]           position;
    logic                       out_valid;
    logic                       out_stall;
    logic [STAT_W-1:0]          status;
    logic [FIDX_W-1:0]          found_index;
    logic signed [VALUE_W-1:0]  read_value;
    logic [CNT_W-1:0]           count;

    list_scoreboard board;

    // Idling percentages for each side; changed between phases of the run.
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    bit          hold_receiver;
    int unsigned quiet_cycles;
    bit          failed;

    array_list_sort_search_engine DUT (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_mode        (mode),
        .i_value       (value),
        .i_position    (position),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_status      (status),
        .o_found_index (found_index),
        .o_read_value  (read_value),
        .o_count       (count)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        board = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        mode = '0;
        value = '0;
        position = '0;
        out_stall = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_receiver = 1'b0;
        failed = 1'b0;
    end

    // Receiver: random stall per cycle, or a long hold while hold_receiver is
    // set. Results are sampled at the edge where they are taken.
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall)
            board.check_answer('{status, found_index, read_value, count});
        out_stall <= hold_receiver ? 1'b1 : ($urandom_range(99) < recv_idle_pct);
    end

    // Watchdog on cycles with no handshake on either side.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("array_list_sort_search_engine_test: FAIL");
            $finish;
        end
    end

    // Offers one item, with a random number of idle cycles before it, and
    // returns once the block has accepted it.
    task automatic send_item(logic [MODE_W-1:0] m, logic signed [VALUE_W-1:0] v,
                             logic [POS_W-1:0] p);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        mode <= m;
        value <= v;
        position <= p;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        board.note_item(m, v, p);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (board.owed.size() != 0) @(posedge clk);
    endtask

    // Values are mostly drawn from a narrow range so that searches hit and
    // sorts see duplicates; the rest are fully random or extreme.
    function automatic logic signed [VALUE_W-1:0] pick_value();
        case ($urandom_range(5))
            0: return $urandom();
            1: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
            default: return $signed($urandom_range(40)) - 20;
        endcase
    endfunction

    // Positions are mostly valid, sometimes at or just past the count, and
    // occasionally anywhere in the field.
    function automatic logic [POS_W-1:0] pick_position();
        case ($urandom_range(7))
            0: return POS_W'($urandom_range(127));
            1: return POS_W'(board.used);
            2: return POS_W'(board.used + 1);
            default: return board.used == 0 ? '0 : POS_W'($urandom_range(board.used - 1));
        endcase
    endfunction

    // Appends are the most frequent mode so that the list grows; sorts are
    // kept rare because they are by far the slowest operation.
    task automatic send_random_item();
        int unsigned r;
        logic [MODE_W-1:0] m;
        r = $urandom_range(99);
        if (r < 30) m = MODE_APPEND;
        else if (r < 40) m = MODE_INSERT;
        else if (r < 50) m = MODE_UPDATE;
        else if (r < 60) m = MODE_DELETE;
        else if (r < 63) m = MODE_SORTDSC;
        else if (r < 68) m = MODE_SORTASC;
        else if (r < 76) m = MODE_LSEARCH;
        else if (r < 86) m = MODE_BSEARCH;
        else if (r < 95) m = MODE_READ;
        else if (r < 97) m = MODE_CLEAR;
        else m = MODE_W'($urandom_range(15, 10));
        send_item(m, pick_value(), pick_position());
    endtask

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: empty-list errors, extremes, every operation, and
        // the unused modes.
        send_item(MODE_READ, 0, 0);
        send_item(MODE_DELETE, 0, 0);
        send_item(MODE_UPDATE, 0, 0);
        send_item(MODE_INSERT, 5, 1);
        send_item(MODE_LSEARCH, 3, 0);
        send_item(MODE_BSEARCH, 3, 0);
        send_item(MODE_APPEND, 32'sh7fffffff, 7'h7f);
        send_item(MODE_APPEND, 32'sh80000000, 0);
        send_item(MODE_INSERT, -1, 2);
        send_item(MODE_INSERT, 0, 0);
        send_item(MODE_UPDATE, 32'sh55555555, 1);
        send_item(MODE_SORTASC, 0, 0);
        send_item(MODE_BSEARCH, 32'sh7fffffff, 0);
        send_item(MODE_LSEARCH, -1, 0);
        send_item(MODE_READ, 0, 3);
        send_item(MODE_READ, 0, 4);
        send_item(MODE_SORTDSC, 0, 0);
        send_item(MODE_DELETE, 0, 3);
        send_item(MODE_DELETE, 0, 0);
        send_item(4'd10, 32'shaaaaaaaa, 7'h2a);
        send_item(4'd15, 0, 0);
        // Fill to capacity, then the full-list errors and a full sort.
        while (board.used < CAP) send_item(MODE_APPEND, $urandom(), 0);
        send_item(MODE_APPEND, 1, 0);
        send_item(MODE_INSERT, 1, 0);
        send_item(MODE_SORTASC, 0, 0);
        send_item(MODE_READ, 0, POS_W'(CAP - 1));
        send_item(MODE_DELETE, 0, POS_W'(CAP - 1));
        send_item(MODE_CLEAR, 0, 0);

        // Pressure: the receiver holds off for a long stretch while items
        // keep coming, then the sender pauses until all results are back.
        hold_receiver = 1'b1;
        fork
            begin
                repeat (300) @(posedge clk);
                hold_receiver = 1'b0;
            end
            repeat (6) send_item(MODE_APPEND, pick_value(), 0);
        join
        wait_drained();

        send_idle_pct = 31;
        recv_idle_pct = 80;
        repeat (65) send_random_item();
        wait_drained();
        send_idle_pct = 80;
        recv_idle_pct = 31;
        repeat (65) send_random_item();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (65) send_random_item();

        wait_drained();
        repeat (50) @(posedge clk);
        if (board.mismatches != 0 || board.owed.size() != 0) failed = 1'b1;
        if (!failed)
            $display("array_list_sort_search_engine_test: PASS");
        else
            $display("array_list_sort_search_engine_test: FAIL");
        $finish;
    end

endmodule
